// ===== sv/n2a_pkg.sv =====
// shared types, constants and character tables of the number to ascii formatter
package n2a_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int VALUE_W     = 64;
    localparam int OPCODE_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int TOTAL_W     = 5;
    localparam int DEC_W       = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = BCD_DIGITS * 4;
    localparam int NIB_IDX_W   = 4;
    localparam int STEP_W      = $clog2(DEC_W);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcodes on the input stream
    localparam logic [OPCODE_W-1:0] OP_DEC  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_HEX  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PTR  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RESV = 2'd3;

    // fixed characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
    localparam logic [TOTAL_W-1:0] NIL_LEN  = 5'd5;

    localparam logic [CHAR_W-1:0] DIGIT_SET [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [CHAR_W-1:0] NIL_TEXT [8] = '{
        8'h28, 8'h6e, 8'h69, 8'h6c, 8'h29, 8'h00, 8'h00, 8'h00
    };

    // what the back end has to do with a request
    typedef enum logic [1:0] {
        KIND_DEC,
        KIND_HEX,
        KIND_PTR,
        KIND_NIL
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } req_t;

    // front to queue
    typedef struct packed {
        logic push;
        req_t req;
    } push_t;

    // queue to back
    typedef struct packed {
        logic valid;
        req_t req;
    } qhead_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DABBLE,
        BK_PREFIX,
        BK_NIL,
        BK_DIGITS
    } back_state_t;

endpackage

// ===== sv/n2a_front.sv =====
// input side: accepts requests, drops the unused opcode and classifies the rest
module n2a_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [n2a_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            q_full,
    output n2a_pkg::push_t                  push
);
    import n2a_pkg::*;

    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    kind_t               kind;

    // field extraction
    assign opcode = s_axis_tdata[OPCODE_W-1:0];
    assign value  = s_axis_tdata[OPCODE_W +: VALUE_W];

    // accept whenever the queue has room
    assign s_axis_tready = !q_full;

    // classify the request
    always_comb
    begin
        unique case (opcode)
            OP_DEC:  kind = KIND_DEC;
            OP_HEX:  kind = KIND_HEX;
            OP_PTR:  kind = (value == '0) ? KIND_NIL : KIND_PTR;
            default: kind = KIND_DEC;
        endcase
    end

    // push accepted requests, the unused opcode produces nothing
    always_comb
    begin
        push.push      = s_axis_tvalid && s_axis_tready && (opcode != OP_RESV);
        push.req.kind  = kind;
        push.req.value = value;
    end

endmodule

// ===== sv/n2a_queue.sv =====
// short request queue decoupling the front from the back end
module n2a_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  n2a_pkg::push_t push,
    input  logic           pop,
    output logic           full,
    output n2a_pkg::qhead_t head
);
    import n2a_pkg::*;

    req_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push  = push.push && !full;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.req   = mem[rd_ptr_reg];

    // pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.req;
        end
    end

endmodule

// ===== sv/n2a_back.sv =====
// back end: decimal conversion, digit scan, "0x" prefix, "(nil)" text and character output register
module n2a_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  n2a_pkg::qhead_t                 head,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [n2a_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import n2a_pkg::*;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [VALUE_W-1:0]    digits_reg;
    logic [DEC_W-1:0]      bin_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [NIB_IDX_W-1:0]  idx_reg;
    logic [TOTAL_W-1:0]    chars_reg;
    logic                  started_reg;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_last_reg;
    logic [TOTAL_W-1:0]    out_total_reg;

    logic                  slot_free;
    logic                  emit;
    logic                  skip;
    logic [CHAR_W-1:0]     emit_char;
    logic                  emit_last;
    logic [3:0]            nib;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BCD_W-1:0]      bcd_next;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign nib       = digits_reg[{idx_reg, 2'b00} +: 4];

    // one double dabble step: add three to large digits, then shift in a bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (digits_reg[i*4 +: 4] >= 4'd5) ?
                                digits_reg[i*4 +: 4] + 4'd3 : digits_reg[i*4 +: 4];
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[DEC_W-1]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.req.kind)
                        KIND_DEC: state_next = BK_DABBLE;
                        KIND_HEX: state_next = BK_DIGITS;
                        KIND_PTR: state_next = BK_PREFIX;
                        KIND_NIL: state_next = BK_NIL;
                    endcase
                end
            end
            BK_DABBLE:
            begin
                if (step_reg == STEP_W'(DEC_W - 1))
                begin
                    state_next = BK_DIGITS;
                end
            end
            BK_PREFIX:
            begin
                if (emit && idx_reg[0])
                begin
                    state_next = BK_DIGITS;
                end
            end
            BK_NIL:
            begin
                if (emit && (idx_reg == NIB_IDX_W'(NIL_LEN - 1'b1)))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIGITS:
            begin
                if ((emit || skip) && (idx_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        skip      = 1'b0;
        emit_char = CHAR_ZERO;
        emit_last = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head.valid;
            end
            BK_DABBLE:
            begin
            end
            BK_PREFIX:
            begin
                emit      = slot_free;
                emit_char = idx_reg[0] ? CHAR_X : CHAR_ZERO;
            end
            BK_NIL:
            begin
                emit      = slot_free;
                emit_char = NIL_TEXT[idx_reg[2:0]];
                emit_last = (idx_reg == NIB_IDX_W'(NIL_LEN - 1'b1));
            end
            BK_DIGITS:
            begin
                // leading zeros are passed over, the units digit always prints
                skip      = (nib == 4'd0) && !started_reg && (idx_reg != '0);
                emit      = !skip && slot_free;
                emit_char = DIGIT_SET[nib];
                emit_last = (idx_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    digits_reg  <= (head.req.kind == KIND_DEC) ? '0 : head.req.value;
                    bin_reg     <= head.req.value[DEC_W-1:0];
                    idx_reg     <= (head.req.kind == KIND_HEX) ? '1 : '0;
                    step_reg    <= '0;
                    chars_reg   <= '0;
                    started_reg <= 1'b0;
                end
            end
            BK_DABBLE:
            begin
                digits_reg <= {{(VALUE_W - BCD_W){1'b0}}, bcd_next};
                bin_reg    <= {bin_reg[DEC_W-2:0], 1'b0};
                step_reg   <= step_reg + 1'b1;
                idx_reg    <= NIB_IDX_W'(BCD_DIGITS - 1);
            end
            BK_PREFIX:
            begin
                if (emit)
                begin
                    chars_reg <= chars_reg + 1'b1;
                    idx_reg   <= idx_reg[0] ? '1 : idx_reg + 1'b1;
                end
            end
            BK_NIL:
            begin
                if (emit)
                begin
                    chars_reg <= chars_reg + 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                end
            end
            BK_DIGITS:
            begin
                if (skip)
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
                else if (emit)
                begin
                    chars_reg   <= chars_reg + 1'b1;
                    started_reg <= 1'b1;
                    idx_reg     <= idx_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // output holding register
        if (emit)
        begin
            out_char_reg  <= emit_char;
            out_last_reg  <= emit_last;
            out_total_reg <= emit_last ? chars_reg + 1'b1 : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - CHAR_W - TOTAL_W){1'b0}}, out_total_reg, out_char_reg};

endmodule

// ===== sv/number_to_ascii_formatter_unit.sv =====
// top level of the number to ascii formatter
//
// requests arrive on the s_axis stream: opcode 0 prints the low 32 bits of
// the value as unsigned decimal, 1 prints lowercase hex with no leading
// zeros, 2 prints "0x" and the hex digits, or "(nil)" for zero; opcode 3 is
// dropped without output. characters leave on the m_axis stream, most
// significant first, one per transfer, tlast on the final one, which also
// carries the character count.
// a two-entry queue sits between the input side and the back end, so new
// requests are accepted while an earlier one is still being printed.
// per request the back end loads it, runs double dabble on the low 32 bits
// in decimal mode, then scans the digits one by one (10 in decimal, 16 in
// hex, leading zeros included), each printed digit waiting for a free
// output register. with the back end idle, a request passes the queue and
// the load before its first character enters the output register; each
// leading zero nibble delays the first hex character further.
// reset empties the queue and the output register; a stalled receiver holds
// the current character and the back end waits, then the queue fills and
// s_axis_tready drops.
module number_to_ascii_formatter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode [1:0], value [65:2], zero fill [71:66]
    input  logic [n2a_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // char_code [7:0], total_chars [12:8], zero fill [15:13]
    output logic [n2a_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import n2a_pkg::*;

    push_t  push;
    qhead_t head;
    logic   q_full;
    logic   pop;

    // input side
    n2a_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .push          (push)
    );

    // request queue
    n2a_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // conversion and output
    n2a_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
